FILE: rtl/smv_pkg.sv
// smv_pkg: shared constants, types and the exp table for the softmax vector core.
// No dependencies.
`default_nettype none
package smv_pkg;

  localparam int MAX_LEN = 16;
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int EXP_W   = 17;
  localparam int SUM_W   = EXP_W + CNT_W;
  localparam int QDIV_W  = 17;
  localparam int STEP_W  = 5;

  typedef logic [31:0] frac_tab_t [256];

  // truncating long division, elaboration only
  function automatic logic [63:0] div_floor(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-x) in Q1.31 by a truncating Taylor series, elaboration only
  function automatic logic [31:0] series_q31(input logic [63:0] x);
    logic [63:0] term;
    logic signed [63:0] acc;
    term = 64'h8000_0000;
    acc  = 64'sh8000_0000;
    for (int k = 1; k <= 24; k++) begin
      term = div_floor((term * x) >> 31, 64'(k));
      if ((k & 1) != 0) acc = acc - $signed(term);
      else              acc = acc + $signed(term);
    end
    if (acc < 0) acc = 0;
    if (acc > 64'sh8000_0000) acc = 64'sh8000_0000;
    return acc[31:0];
  endfunction

  function automatic frac_tab_t build_frac_tab();
    frac_tab_t t;
    for (int r = 0; r < 256; r++) begin
      t[r] = series_q31(64'(r) << 23);
    end
    return t;
  endfunction

  localparam frac_tab_t   EXP_FRAC = build_frac_tab();
  localparam logic [31:0] EXP_NEG1 = series_q31(64'h8000_0000);

endpackage
`default_nettype wire

FILE: rtl/softmax_vector_core.sv
// softmax_vector_core: max-subtracted fixed-point softmax over a stored vector.
// Depends on smv_pkg.
`default_nettype none
// Scores (signed Q8.8) load one item per cycle into a score memory while the
// running maximum is tracked; up to smv_pkg::MAX_LEN elements are kept and any
// beyond are dropped. The item with last_in set closes the vector. The core
// then makes two passes over the stored elements, one memory read each:
// exp pass: d = max - score, exp(-d/256) as a table lookup for the fraction
// times one Q1.31 multiply by exp(-1) per cycle for each whole unit of d (up
// to 16), giving e in Q1.16 which is written to the exp memory and summed;
// divide pass: floor(e*65536/sum) by a restoring divider, one quotient bit per
// cycle, then the result sits in an output register until taken. No input is
// taken while the passes run (in_stall high).
module softmax_vector_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] score,
  input  wire logic        last_in,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic [15:0]      prob,
  output logic [5:0]       position,
  output logic             last_out,
  output logic             out_valid,
  input  wire logic        out_stall
);

  typedef enum logic [6:0] {
    S_LOAD     = 7'b0000001,
    S_EXP_RD   = 7'b0000010,
    S_EXP_INIT = 7'b0000100,
    S_EXP_MUL  = 7'b0001000,
    S_DIV_RD   = 7'b0010000,
    S_DIV_STEP = 7'b0100000,
    S_OUT      = 7'b1000000
  } state_t;

  state_t state;

  // element memories, synchronous (registered) read
  logic [15:0]                score_mem [smv_pkg::MAX_LEN];
  logic [smv_pkg::EXP_W-1:0]  exp_mem   [smv_pkg::MAX_LEN];
  logic [15:0]                score_rd;
  logic [smv_pkg::EXP_W-1:0]  exp_rd;

  logic [smv_pkg::CNT_W-1:0]  count;
  logic [smv_pkg::IDX_W-1:0]  idx;
  logic signed [15:0]         run_max;
  logic [smv_pkg::SUM_W-1:0]  exp_sum;

  // exp datapath
  logic [31:0] v;
  logic [4:0]  qcnt;
  logic [63:0] prod;
  logic [32:0] v_round;
  logic [smv_pkg::EXP_W-1:0] e_val;
  logic [15:0] diff;

  // divider
  logic [smv_pkg::SUM_W-1:0]  rem;
  logic                       next_bit;
  logic [smv_pkg::QDIV_W-1:0] quot;
  logic [smv_pkg::STEP_W-1:0] steps;
  logic [smv_pkg::SUM_W:0]    trial;
  logic                       fits;

  logic in_acc, out_acc, is_last_idx;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall  = (state != S_LOAD);
  assign out_valid = (state == S_OUT);
  assign is_last_idx = ({1'b0, idx} == smv_pkg::CNT_W'(count - 1'b1));

  assign diff    = 16'(run_max - $signed(score_rd));
  assign prod    = 64'(v) * 64'(smv_pkg::EXP_NEG1);
  assign v_round = 33'(v) + 33'(1 << 14);
  assign e_val   = (v < 32'(1 << 15)) ? '0 : v_round[31:15];

  assign trial = {rem, next_bit};
  assign fits  = (trial >= {1'b0, exp_sum});

  always_ff @(posedge clk) begin
    if (state == S_LOAD && in_acc && count < smv_pkg::CNT_W'(smv_pkg::MAX_LEN))
      score_mem[count[smv_pkg::IDX_W-1:0]] <= score;
    if (state == S_EXP_MUL && qcnt == '0)
      exp_mem[idx] <= e_val;
    score_rd <= score_mem[idx];
    exp_rd   <= exp_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      count   <= '0;
      idx     <= '0;
      run_max <= 16'sh8000;
      exp_sum <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (count < smv_pkg::CNT_W'(smv_pkg::MAX_LEN)) begin
              count <= count + 1'b1;
              if ($signed(score) > run_max) run_max <= $signed(score);
            end
            if (last_in) begin
              idx     <= '0;
              exp_sum <= '0;
              state   <= S_EXP_RD;
            end
          end
        end
        S_EXP_RD: state <= S_EXP_INIT;
        S_EXP_INIT: begin
          v     <= smv_pkg::EXP_FRAC[diff[7:0]];
          qcnt  <= (diff[15:8] > 8'd16) ? 5'd16 : diff[12:8];
          state <= S_EXP_MUL;
        end
        S_EXP_MUL: begin
          if (qcnt != '0) begin
            v    <= prod[62:31];
            qcnt <= qcnt - 1'b1;
          end else begin
            exp_sum <= exp_sum + smv_pkg::SUM_W'(e_val);
            if (is_last_idx) begin
              idx   <= '0;
              state <= S_DIV_RD;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_EXP_RD;
            end
          end
        end
        S_DIV_RD: begin
          state <= S_DIV_STEP;
          steps <= '0;
          quot  <= '0;
        end
        S_DIV_STEP: begin
          // first step seeds from the memory data: remainder e>>1, next bit e[0]
          if (steps == '0) begin
            rem      <= smv_pkg::SUM_W'(exp_rd >> 1);
            next_bit <= exp_rd[0];
            steps    <= steps + 1'b1;
          end else begin
            rem      <= fits ? smv_pkg::SUM_W'(trial - {1'b0, exp_sum})
                             : smv_pkg::SUM_W'(trial);
            quot     <= {quot[smv_pkg::QDIV_W-2:0], fits};
            next_bit <= 1'b0;
            steps    <= steps + 1'b1;
            if (steps == smv_pkg::STEP_W'(smv_pkg::QDIV_W)) state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (is_last_idx) begin
              count   <= '0;
              run_max <= 16'sh8000;
              exp_sum <= '0;
              idx     <= '0;
              state   <= S_LOAD;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_DIV_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign prob     = quot[16] ? 16'hFFFF : quot[15:0];
  assign position = 6'(idx);
  assign last_out = is_last_idx;

endmodule
`default_nettype wire

FILE: rtl/smv_checker.sv
// smv_checker: port-level assertions for softmax_vector_core, plus its bind.
// Depends on softmax_vector_core's port list.
`default_nettype none
module smv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        last_in,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        last_out,
  input wire logic [15:0] prob
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(prob))
    else $error("stalled result changed");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while emitting");
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_in |=> in_stall)
    else $error("vector end did not start compute");
  a_end_frees: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_out |=> !out_valid && !in_stall)
    else $error("not back to loading after final result");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind softmax_vector_core smv_checker u_smv_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .last_in(last_in), .out_valid(out_valid), .out_stall(out_stall),
  .last_out(last_out), .prob(prob)
);
`default_nettype wire

FILE: sim/tb_top.sv
// tb_top: self-checking testbench for softmax_vector_core.
// Depends on smv_pkg and softmax_vector_core; predicts the probabilities itself.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [15:0] score = '0;
  logic        last_in = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] prob;
  logic [5:0]  position;
  logic        last_out;
  logic        out_valid;
  logic        out_stall = 1'b0;

  softmax_vector_core uut (
    .clk(clk), .rst(rst), .score(score), .last_in(last_in), .in_valid(in_valid),
    .in_stall(in_stall), .prob(prob), .position(position), .last_out(last_out),
    .out_valid(out_valid), .out_stall(out_stall)
  );

  always #10 clk = ~clk;

  // one expected probability item
  typedef struct packed {
    logic [15:0] prob;
    logic [5:0]  position;
    logic        last;
  } prob_item_t;

  prob_item_t prob_queue[$];
  int errors = 0;

  // predictor state: scores of the vector being loaded and its maximum
  logic signed [15:0] vec_scores[smv_pkg::MAX_LEN];
  int                 vec_len = 0;
  logic signed [15:0] vec_max = -16'sd32768;

  // idle shaping: percent chance of gap / stall, and a long hold-off request
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  // exp(-x) in Q1.31 by truncating Taylor series, x in Q1.31
  function automatic longint unsigned taylor_exp(longint unsigned x);
    longint unsigned term;
    longint          acc;
    term = 64'h8000_0000;
    acc  = 64'h8000_0000;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * x) >> 31) / k;
      if (k & 1) acc -= longint'(term);
      else       acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > 64'h8000_0000) acc = 64'h8000_0000;
    return longint'(acc);
  endfunction

  // exp(-d/256) as Q1.16, rounded, underflow to zero
  function automatic int unsigned exp_of_gap(int unsigned d);
    longint unsigned v, g;
    int unsigned     whole;
    whole = d >> 8;
    v = taylor_exp(longint'(d & 8'hFF) << 23);
    g = taylor_exp(64'h8000_0000);
    if (whole > 16) whole = 16;
    for (int i = 0; i < whole; i++) v = (v * g) >> 31;
    if (v < (1 << 15)) return 0;
    return int'((v + (1 << 14)) >> 15);
  endfunction

  // accept one score into the predictor; on last, queue the probabilities
  task automatic predict_softmax(logic [15:0] s, logic lst);
    int unsigned es[smv_pkg::MAX_LEN];
    int unsigned total;
    longint unsigned p;
    prob_item_t  it;
    if (vec_len < smv_pkg::MAX_LEN) begin
      vec_scores[vec_len] = s;
      if ($signed(s) > vec_max) vec_max = s;
      vec_len++;
    end
    if (!lst) return;
    total = 0;
    for (int i = 0; i < vec_len; i++) begin
      es[i] = exp_of_gap(int'(vec_max) - int'(vec_scores[i]));
      total += es[i];
    end
    for (int i = 0; i < vec_len; i++) begin
      p = (total != 0) ? (longint'(es[i]) << 16) / total : 0;
      if (p > 65535) p = 65535;
      it.prob = p[15:0];
      it.position = i[5:0];
      it.last = (i == vec_len - 1);
      prob_queue.push_back(it);
    end
    vec_len = 0;
    vec_max = -16'sd32768;
  endtask

  // result side: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // checker: compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    prob_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (prob_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected result prob=%0d pos=%0d last=%0b", $time,
                 prob, position, last_out);
      end else begin
        want = prob_queue.pop_front();
        if (prob !== want.prob || position !== want.position ||
            last_out !== want.last) begin
          errors++;
          $display("%0t: mismatch expected prob=%0d pos=%0d last=%0b, got %0d %0d %0b",
                   $time, want.prob, want.position, want.last, prob, position, last_out);
        end
      end
    end
  end

  // directed rows: score, last flag, expected prob of this element (-1: predictor)
  typedef struct {
    logic [15:0] s;
    logic        lst;
    int          want;
  } score_row_t;

  score_row_t directed[] = '{
    '{16'h0000, 1'b1, 65535},                          // single element: saturates
    '{16'h7FFF, 1'b0, 65535}, '{16'h8000, 1'b1, 0},    // extremes, tiny exp underflows
    '{16'h0100, 1'b0, 32768}, '{16'h0100, 1'b1, 32768}, // equal scores, half each
    '{16'h0000, 1'b0, -1}, '{16'hFF00, 1'b0, -1}, '{16'hFFFF, 1'b0, -1},
    '{16'h1000, 1'b0, -1}, '{16'h00FF, 1'b1, -1},
    '{16'h8000, 1'b0, 32768}, '{16'h8000, 1'b1, 32768} // all most negative
  };

  // one item handed to the block; waits for acceptance
  task automatic send_score(logic [15:0] s, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    score <= s;
    last_in <= lst;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_softmax(s, lst);
  endtask

  // random vector: half nearby scores so exps stay meaningful, plus random and extreme ones
  task automatic send_random_vector(int len);
    logic [15:0] base, s;
    base = $urandom;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(3))
        0: s = $urandom;
        1: s = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        default: s = base + 16'($urandom_range(4095)) - 16'd2048;
      endcase
      send_score(s, i == len - 1);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (prob_queue.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  int sent;
  int len;
  int vec_first;
  int n_el;

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; typed values replace the predicted ones where given
    vec_first = 0;
    foreach (directed[i]) begin
      send_score(directed[i].s, directed[i].lst);
      if (directed[i].lst) begin
        n_el = i - vec_first + 1;
        for (int k = 0; k < n_el; k++) begin
          if (directed[vec_first + k].want >= 0)
            prob_queue[prob_queue.size() - n_el + k].prob =
              16'(directed[vec_first + k].want);
        end
        vec_first = i + 1;
      end
    end
    drain();

    // overflow: 20 elements, only the first 16 kept
    for (int i = 0; i < 20; i++) send_score(16'(i * 64), i == 19);
    drain();

    // long receiver hold-off while the sender keeps offering
    hold_cycles = 400;
    for (int v = 0; v < 3; v++) send_random_vector(8);
    drain();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 85 : (ph == 3) ? 6 : 0;
      recv_stall_pct = (ph == 2) ? 85 : (ph == 3) ? 6 : 0;
      sent = 0;
      while (sent < 36) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 6);
        send_random_vector(len);
        sent += len;
      end
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
